// File: sv/merge_sort_engine_defines.svh
// ---------------------------------------------------------------------------
// merge_sort_engine assertion macros
// Shared property wrappers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("merge_sort_engine: property failed");

// Next-cycle implication, sampled on clk, off during rst.
`define MSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("merge_sort_engine: property failed");

`endif

// File: sv/mse_pkg.sv
// ---------------------------------------------------------------------------
// mse_pkg
// Sizes and controller/datapath interface types for the merge sort engine.
// ---------------------------------------------------------------------------
package mse_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);      // index into one bank
  localparam int CNT_W    = $clog2(CAPACITY + 1);  // holds 0..CAPACITY
  localparam int POS_W    = CNT_W + 1;             // holds lo + 2*width
  localparam int ADDR_W   = IDX_W + 1;             // bank bit + index

  // controller -> datapath
  typedef struct packed {
    logic load;   // store one input beat
    logic init;   // start first merge pass
    logic step;   // emit one merged element into the other bank
    logic emit;   // read one sorted element out
    logic clear;  // end of set
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic n_le1;      // set of zero or one element: nothing to merge
    logic sort_done;  // this step closes the last pass
    logic emit_last;  // this emit is the final element
  } stat_t;

endpackage

// File: sv/mse_ctrl.sv
// ---------------------------------------------------------------------------
// mse_ctrl
// Sequencer for load, merge passes and emission.
// ---------------------------------------------------------------------------
module mse_ctrl
  import mse_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  last,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INIT   = 6'b000010,
    S_READ   = 6'b000100,
    S_MERGE  = 6'b001000,
    S_EMIT   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = stat.n_le1 ? S_EMIT : S_READ;
      end
      S_READ: begin
        state_next = S_MERGE;
      end
      S_MERGE: begin
        cmd.step   = 1'b1;
        state_next = stat.sort_done ? S_EMIT : S_READ;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.emit_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.clear  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: sv/mse_dp.sv
// ---------------------------------------------------------------------------
// mse_dp
// Two-bank element memory, run pointers, compare/select and result regs.
// ---------------------------------------------------------------------------
module mse_dp
  import mse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic signed [DATA_W-1:0] value,
  output stat_t                    stat,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     final_res,
  output logic                     truncated
);

  // bank 0 = primary store, bank 1 = scratch store
  logic signed [DATA_W-1:0] mem [2**ADDR_W];
  logic signed [DATA_W-1:0] rd_a, rd_b;

  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             bank;   // bank holding the current source runs
  logic [CNT_W-1:0] width, lo, mid, hi, a, b, k;

  logic [ADDR_W-1:0] raddr_a, raddr_b, waddr;
  logic [DATA_W-1:0] wdata;
  logic              we;

  logic              sel_a, run_end, pass_end, has_room;
  logic [CNT_W-1:0]  k_inc, w_dbl, w_nxt, mid_nxt, hi_nxt;
  logic [POS_W-1:0]  lo_adv, lo_nxt;
  logic signed [DATA_W-1:0] pick;

  function automatic logic [CNT_W-1:0] clamp_n(input logic [POS_W-1:0] pos,
                                               input logic [CNT_W-1:0] n);
    logic [POS_W-1:0] n_ext;
    n_ext = {1'b0, n};
    return (pos > n_ext) ? n : pos[CNT_W-1:0];
  endfunction

  assign has_room = (count < CNT_W'(CAPACITY));

  always_comb begin
    sel_a    = (a < mid) && ((b >= hi) || (rd_a <= rd_b));
    pick     = sel_a ? rd_a : rd_b;
    k_inc    = k + CNT_W'(1);
    run_end  = (k_inc == hi);
    lo_adv   = {1'b0, lo} + ({1'b0, width} << 1);
    pass_end = run_end && (lo_adv >= {1'b0, count});
    w_dbl    = width << 1;
    w_nxt    = pass_end ? w_dbl : width;
    lo_nxt   = pass_end ? '0 : lo_adv;
    mid_nxt  = clamp_n(lo_nxt + {1'b0, w_nxt}, count);
    hi_nxt   = clamp_n(lo_nxt + ({1'b0, w_nxt} << 1), count);
  end

  assign stat.n_le1     = (count <= CNT_W'(1));
  assign stat.sort_done = pass_end && (w_dbl >= count);
  assign stat.emit_last = (k_inc == count);

  // port A: run head a while merging, emit index k while emitting
  assign raddr_a = cmd.emit ? {bank, k[IDX_W-1:0]} : {bank, a[IDX_W-1:0]};
  assign raddr_b = {bank, b[IDX_W-1:0]};

  always_comb begin
    we    = 1'b0;
    waddr = {~bank, k[IDX_W-1:0]};
    wdata = pick;
    if (cmd.load) begin
      we    = has_room;
      waddr = {1'b0, count[IDX_W-1:0]};
      wdata = value;
    end else if (cmd.step) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ovf    <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
      if (cmd.load) begin
        if (has_room) begin
          count <= count + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.clear) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      final_res <= stat.emit_last;
      truncated <= ovf;
      k         <= k_inc;
    end
    if (cmd.init) begin
      bank  <= 1'b0;
      width <= CNT_W'(1);
      lo    <= '0;
      a     <= '0;
      k     <= '0;
      mid   <= clamp_n(POS_W'(1), count);
      b     <= clamp_n(POS_W'(1), count);
      hi    <= clamp_n(POS_W'(2), count);
    end
    if (cmd.step) begin
      if (run_end) begin
        width <= w_nxt;
        lo    <= lo_nxt[CNT_W-1:0];
        a     <= lo_nxt[CNT_W-1:0];
        k     <= lo_nxt[CNT_W-1:0];
        mid   <= mid_nxt;
        b     <= mid_nxt;
        hi    <= hi_nxt;
        if (pass_end) begin
          bank <= ~bank;
        end
      end else begin
        k <= k_inc;
        if (sel_a) begin
          a <= a + CNT_W'(1);
        end else begin
          b <= b + CNT_W'(1);
        end
      end
    end
  end

  assign sorted_value = rd_a;

endmodule

// File: sv/merge_sort_engine.sv
// Flow: after the edge that takes the beat marked last, the set goes through init,
//   then a read and a merge step per element (n elements) in each of p = ceil(log2 n) passes.
// Throughput: loads take 1 beat per cycle while busy is low; the set then keeps busy high
//   through init, merge, n emits and closing; results go out back to back.
// The receiver cannot stall: each result beat lasts one cycle, marked by strobe.
// Reset: synchronous rst clears sequencer, count and overflow flag; stores are not cleared.
// ---------------------------------------------------------------------------
// merge_sort_engine
// Collects signed values, sorts them with bottom-up stable merges between two
// memory banks, and streams them out in ascending order.
// ---------------------------------------------------------------------------
module merge_sort_engine
  import mse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input beat: taken when start && !busy
  input  logic                     start,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  output logic                     busy,
  // result beat: valid for the single cycle that strobe is high
  output logic                     strobe,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     final_res,
  output logic                     truncated
);

  // Controller and datapath talk only through these two bundles.
  cmd_t  cmd;
  stat_t stat;

  // Sequencer: idle/load -> init -> (read, merge)* -> emit* -> finish.
  mse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (last),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Memory banks, run pointers and output registers. The sorted set ends up
  // in whichever bank the last pass wrote; emission reads it from there.
  mse_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .stat         (stat),
    .strobe       (strobe),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .truncated    (truncated)
  );

endmodule

// File: sv/mse_checker.sv
// ---------------------------------------------------------------------------
// mse_checker
// Port-level properties of the merge sort engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "merge_sort_engine_defines.svh"

module mse_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic last,
  input logic busy,
  input logic strobe,
  input logic final_res
);

  // results only come out while a set is being processed
  `MSE_ASSERT_IMP(a_strobe_busy, strobe, busy)
  // a set's results are back to back until the final one
  `MSE_ASSERT_NXT(a_emit_run, strobe && !final_res, strobe)
  // nothing follows the final result
  `MSE_ASSERT_NXT(a_final_gap, strobe && final_res, !strobe && !busy)
  // a beat not marked last keeps the block open for more
  `MSE_ASSERT_NXT(a_load_open, start && !busy && !last, !busy)
  // the beat marked last starts the sort
  `MSE_ASSERT_NXT(a_last_busy, start && !busy && last, busy)

endmodule

bind merge_sort_engine mse_checker u_mse_checker (.*);

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for merge_sort_engine. Feeds sets of signed values
// through the start/busy port, predicts the ascending stream that each set
// yields (with the truncation flag once a set runs past CAPACITY), and
// compares every strobed beat against that prediction in order.
// ---------------------------------------------------------------------------
module tb_top
  import mse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ITEMS = 430;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // Per-set value flavors for the random part
  typedef enum int {
    VALS_FULL,     // any 32-bit pattern
    VALS_NARROW,   // tight range, lots of duplicates
    VALS_CORNERS   // extremes and values around zero
  } val_mix_t;

  // One sorted beat as the block should present it
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     fin;
    logic                     trunc;
  } sorted_beat_t;

  // One row of the directed table; when typed is set, the row closes a
  // single-element set whose one beat is given by hand.
  typedef struct {
    logic signed [DATA_W-1:0] val;
    logic                     is_last;
    bit                       typed;
    logic signed [DATA_W-1:0] typed_val;
  } stim_row_t;

  localparam int NUM_ROWS = 23;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic signed [DATA_W-1:0] value;
  logic                     last;
  logic                     busy;
  logic                     strobe;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     final_res;
  logic                     truncated;

  // Predictor state: the set being collected and its overflow flag
  logic signed [DATA_W-1:0] open_set[$];
  bit                       open_overflow;

  // Beats still owed by the block, oldest first
  sorted_beat_t             owed_beats[$];
  sorted_beat_t             want;

  int mismatch_count   = 0;
  int beats_checked    = 0;
  int sets_closed      = 0;
  int values_sent      = 0;
  int truncated_sets   = 0;
  bit calm_set         = 0;   // set sent back to back, no gaps

  stim_row_t directed_rows [NUM_ROWS] = '{
    // single-element sets: the one beat is the value itself, final, not truncated
    '{VAL_MIN,        1'b1, 1'b1, VAL_MIN},
    '{VAL_MAX,        1'b1, 1'b1, VAL_MAX},
    '{32'sd0,         1'b1, 1'b1, 32'sd0},
    '{-32'sd1,        1'b1, 1'b1, -32'sd1},
    // two elements, descending then ascending
    '{32'sd5,         1'b0, 1'b0, 32'sd0},
    '{-32'sd5,        1'b1, 1'b0, 32'sd0},
    '{-32'sd5,        1'b0, 1'b0, 32'sd0},
    '{32'sd5,         1'b1, 1'b0, 32'sd0},
    // mixed extremes, crosses several merge passes
    '{VAL_MAX,        1'b0, 1'b0, 32'sd0},
    '{VAL_MIN,        1'b0, 1'b0, 32'sd0},
    '{32'sd0,         1'b0, 1'b0, 32'sd0},
    '{-32'sd1,        1'b0, 1'b0, 32'sd0},
    '{32'sd1,         1'b0, 1'b0, 32'sd0},
    '{32'h5555_5555,  1'b0, 1'b0, 32'sd0},
    '{32'hAAAA_AAAA,  1'b0, 1'b0, 32'sd0},
    '{VAL_MAX,        1'b0, 1'b0, 32'sd0},
    '{VAL_MIN,        1'b1, 1'b0, 32'sd0},
    // all equal
    '{32'sd7,         1'b0, 1'b0, 32'sd0},
    '{32'sd7,         1'b0, 1'b0, 32'sd0},
    '{32'sd7,         1'b1, 1'b0, 32'sd0},
    // odd size, uneven last run
    '{32'sd3,         1'b0, 1'b0, 32'sd0},
    '{-32'sd2,        1'b0, 1'b0, 32'sd0},
    '{32'sd1,         1'b1, 1'b0, 32'sd0}
  };

  merge_sort_engine u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .value        (value),
    .last         (last),
    .busy         (busy),
    .strobe       (strobe),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .truncated    (truncated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stable ascending order of the collected set, queued as owed beats.
  // An element goes after every earlier element that is not greater.
  function automatic void close_sorted_set();
    logic signed [DATA_W-1:0] ordered[$];
    sorted_beat_t             beat;
    int                       pos;
    ordered = {};
    foreach (open_set[i]) begin
      pos = ordered.size();
      for (int j = 0; j < ordered.size(); j++) begin
        if (ordered[j] > open_set[i]) begin
          pos = j;
          break;
        end
      end
      ordered.insert(pos, open_set[i]);
    end
    foreach (ordered[i]) begin
      beat.val   = ordered[i];
      beat.fin   = (i == ordered.size() - 1);
      beat.trunc = open_overflow;
      owed_beats = {owed_beats, beat};
    end
  endfunction

  // Predictor update for one accepted input beat
  function automatic void absorb_value(logic signed [DATA_W-1:0] v, logic is_last,
                                       bit typed, logic signed [DATA_W-1:0] typed_val);
    sorted_beat_t beat;
    values_sent++;
    if (open_set.size() < CAPACITY) open_set = {open_set, v};
    else open_overflow = 1'b1;
    if (is_last) begin
      if (typed) begin
        beat.val   = typed_val;
        beat.fin   = 1'b1;
        beat.trunc = 1'b0;
        owed_beats = {owed_beats, beat};
      end else begin
        close_sorted_set();
      end
      sets_closed++;
      if (open_overflow) truncated_sets++;
      open_set      = {};
      open_overflow = 1'b0;
    end
  endfunction

  // Mostly back to back, sometimes a short pause, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm_set) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(val_mix_t mix);
    case (mix)
      VALS_NARROW: begin
        return $signed($urandom_range(0, 16)) - 32'sd8;
      end
      VALS_CORNERS: begin
        case ($urandom_range(0, 5))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return VAL_MIN + 32'sd1;
          3: return VAL_MAX - 32'sd1;
          4: return -32'sd1;
          default: return $signed($urandom_range(0, 2));
        endcase
      end
      default: begin
        return $signed($urandom());
      end
    endcase
  endfunction

  // Offer one beat and hold it until the block takes it. The beat is taken
  // at the edge where start is high and busy (pre-edge value) is low.
  task automatic send_beat(logic signed [DATA_W-1:0] v, logic is_last,
                           bit typed, logic signed [DATA_W-1:0] typed_val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    last  <= is_last;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_value(v, is_last, typed, typed_val);
  endtask

  // Hold off the sender until every owed beat has come out
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (owed_beats.size() != 0) @(posedge clk);
  endtask

  // Result checker: a strobed beat is taken at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && strobe) begin
      beats_checked++;
      if (owed_beats.size() == 0) begin
        $display("%0t: sorted beat with nothing owed: value=%0d final=%0b trunc=%0b",
                 $time, sorted_value, final_res, truncated);
        mismatch_count++;
      end else begin
        want = owed_beats.pop_front();
        if (sorted_value !== want.val) begin
          $display("%0t: sorted_value expected %0d got %0d", $time, want.val, sorted_value);
          mismatch_count++;
        end
        if (final_res !== want.fin) begin
          $display("%0t: final_res expected %0b got %0b", $time, want.fin, final_res);
          mismatch_count++;
        end
        if (truncated !== want.trunc) begin
          $display("%0t: truncated expected %0b got %0b", $time, want.trunc, truncated);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int       set_len;
    int       set_idx;
    int       r;
    val_mix_t mix;

    rst   = 1'b1;
    start = 1'b0;
    value = '0;
    last  = 1'b0;
    open_overflow = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_rows[i])
      send_beat(directed_rows[i].val, directed_rows[i].is_last,
                directed_rows[i].typed, directed_rows[i].typed_val);

    // Let the directed sets finish before random traffic starts
    drain_results();

    // Random sets: a full store first, then one that overflows by one (its
    // last beat is dropped), then mostly small sets with a few big ones.
    set_idx = 0;
    while (values_sent < NUM_ITEMS) begin
      if (set_idx == 0) begin
        set_len = CAPACITY;
      end else if (set_idx == 1) begin
        set_len = CAPACITY + 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70)      set_len = $urandom_range(1, 8);
        else if (r < 90) set_len = $urandom_range(9, 24);
        else if (r < 95) set_len = $urandom_range(CAPACITY - 4, CAPACITY);
        else             set_len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      end
      mix      = val_mix_t'($urandom_range(0, 2));
      calm_set = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < set_len; k++)
        send_beat(pick_value(mix), k == set_len - 1, 1'b0, '0);
      calm_set = 0;
      // Occasionally wait for the whole set to come back before the next one
      if ($urandom_range(0, 7) == 0) drain_results();
      set_idx++;
    end

    drain_results();
    // Closing cycle plus margin to catch any stray beat
    repeat (20) @(posedge clk);

    $display("Ran %0d sets, %0d values in, %0d of the sets truncated past capacity.",
             sets_closed, values_sent, truncated_sets);
    $display("Checked %0d sorted beats; %0d field mismatches.", beats_checked, mismatch_count);
    if (mismatch_count == 0 && owed_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d beats still owed", $time, owed_beats.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
